@@ design/bpc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpc_pkg - shared types and constants for the button press classifier
// Timer width, event codes, configuration and debounce status structs, and
// the saturating increment used by every elapsed-time counter.
// ----------------------------------------------------------------------------
package bpc_pkg;

  // Width of the elapsed-time counters (8 to 32)
  localparam int TIMER_WIDTH = 16;
  // Compare width: wide enough for both the counters and the 16-bit thresholds
  localparam int CMP_W = (TIMER_WIDTH > 16) ? TIMER_WIDTH : 16;

  // Register widths and address map
  localparam int DEB_W  = 8;
  localparam int THR_W  = 16;
  localparam int ADDR_W = 4;

  typedef logic [TIMER_WIDTH-1:0] timer_t;

  typedef enum logic [1:0] {
    REG_DEBOUNCE = 2'd0,
    REG_LONG     = 2'd1,
    REG_WINDOW   = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_SINGLE = 2'd1,
    EV_DOUBLE = 2'd2,
    EV_LONG   = 2'd3
  } press_ev_t;

  // Configuration seen by the datapath
  typedef struct packed {
    logic [DEB_W-1:0] debounce_ticks;
    logic [THR_W-1:0] long_press_ticks;
    logic [THR_W-1:0] double_window_ticks;
  } bpc_cfg_t;

  // Debouncer status for the current item
  typedef struct packed {
    logic chg;    // accepted level change this tick
    logic level;  // debounced level after this tick
  } bpc_deb_t;

  // Increment that sticks at all ones
  function automatic timer_t sat_inc(input timer_t v);
    return (&v) ? v : v + TIMER_WIDTH'(1);
  endfunction

endpackage

@@ design/button_press_classifier_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_press_classifier_unit - debounced single/double/long press detector
// Top level: input register, debouncer and classifier, result register, APB.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one transaction per millisecond tick; in_tdata[0] is the raw
//           active-low pin level (0 pressed, 1 released).
//   out_* : one transaction per input tick; out_tdata[1:0] is the event
//           (none, single, double, long), out_tdata[2] the debounced level.
//   cfg_* : APB registers at 0x0 debounce, 0x4 long press, 0x8 double
//           window; write only while no transaction is in flight.
// Each accepted transaction is held in the input register, then in the
// result register, where out_tvalid shows it. Throughput is one transaction
// per cycle while out_tready stays high: the input register feeds
// combinational logic into the result register, and both stages advance
// together.
// When the receiver stalls, the result register holds, then the input
// register fills and in_tready drops; nothing is lost or repeated.
// Reset (synchronous, rst_n low) empties both stages, restores register
// defaults (50, 1000, 300) and puts the button released and idle.
// ----------------------------------------------------------------------------
module button_press_classifier_unit
  import bpc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // input stream
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,   // [0] raw_level, [7:1] zero
  // result stream
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [7:0]        out_tdata,  // [1:0] press_event, [2] stable_level,
                                        // [7:3] zero
  // configuration
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  bpc_cfg_t  cfg;
  bpc_deb_t  deb;
  press_ev_t ev;

  logic      s0_v_r;
  logic      s0_raw_r;
  logic      out_v_r;
  press_ev_t out_ev_r;
  logic      out_lvl_r;
  logic      s1_rdy;
  logic      adv;

  // stage handshakes
  assign s1_rdy    = !out_v_r || out_tready;
  assign adv       = s0_v_r && s1_rdy;
  assign in_tready = !s0_v_r || s1_rdy;

  bpc_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg_o       (cfg)
  );

  bpc_debounce u_deb (
    .clk            (clk),
    .rst_n          (rst_n),
    .adv            (adv),
    .raw            (s0_raw_r),
    .debounce_ticks (cfg.debounce_ticks),
    .deb_o          (deb)
  );

  bpc_fsm u_fsm (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .deb_i (deb),
    .cfg_i (cfg),
    .ev_o  (ev)
  );

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else if (in_tready) begin
      s0_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s0_raw_r <= in_tdata[0];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s1_rdy) begin
      out_v_r <= s0_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_ev_r  <= ev;
      out_lvl_r <= deb.level;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {5'd0, out_lvl_r, out_ev_r};

  // back-pressure only when both stages hold a stalled transaction
  a_ready_drop: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> s0_v_r && out_v_r && !out_tready)
    else $error("input stalled without a full pipeline");

endmodule

@@ design/bpc_cfg_regs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpc_cfg_regs - APB configuration registers
// Debounce time, long press time and double press window. Writes to an
// unmapped address are dropped; reads of it return zero.
// ----------------------------------------------------------------------------
module bpc_cfg_regs
  import bpc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready,
  output bpc_cfg_t          cfg_o
);

  bpc_cfg_t cfg_r;
  logic     wr_en;
  reg_idx_t idx;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign idx        = reg_idx_t'(cfg_paddr[3:2]);
  assign cfg_o      = cfg_r;

  // register write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ticks      <= DEB_W'(50);
      cfg_r.long_press_ticks    <= THR_W'(1000);
      cfg_r.double_window_ticks <= THR_W'(300);
    end else if (wr_en) begin
      case (idx)
        REG_DEBOUNCE: cfg_r.debounce_ticks      <= cfg_pwdata[DEB_W-1:0];
        REG_LONG:     cfg_r.long_press_ticks    <= cfg_pwdata[THR_W-1:0];
        REG_WINDOW:   cfg_r.double_window_ticks <= cfg_pwdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // read-back
  always_comb begin
    case (idx)
      REG_DEBOUNCE: cfg_prdata = 32'(cfg_r.debounce_ticks);
      REG_LONG:     cfg_prdata = 32'(cfg_r.long_press_ticks);
      REG_WINDOW:   cfg_prdata = 32'(cfg_r.double_window_ticks);
      default:      cfg_prdata = 32'd0;
    endcase
  end

endmodule

@@ design/bpc_debounce.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpc_debounce - raw level debouncer
// Counts ticks since the raw level last changed; a new level is taken once
// the count strictly exceeds the debounce time.
// ----------------------------------------------------------------------------
module bpc_debounce
  import bpc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,        // item leaves the input register
  input  logic             raw,
  input  logic [DEB_W-1:0] debounce_ticks,
  output bpc_deb_t         deb_o
);

  logic   prev_r;
  logic   level_r;
  timer_t cnt_r;
  timer_t cnt_nxt;
  logic   chg;

  // next count and change detect
  always_comb begin
    cnt_nxt = (raw != prev_r) ? '0 : sat_inc(cnt_r);
    chg     = (CMP_W'(cnt_nxt) > CMP_W'(debounce_ticks)) && (raw != level_r);
  end

  assign deb_o.chg   = chg;
  assign deb_o.level = chg ? raw : level_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r  <= 1'b1;
      level_r <= 1'b1;
      cnt_r   <= '0;
    end else if (adv) begin
      prev_r  <= raw;
      level_r <= deb_o.level;
      cnt_r   <= cnt_nxt;
    end
  end

  // a level can only be taken once the raw input has repeated
  a_chg_needs_hold: assert property (@(posedge clk) disable iff (!rst_n)
    adv && chg |-> raw == prev_r)
    else $error("debounce change on a raw transition tick");

endmodule

@@ design/bpc_fsm.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpc_fsm - press classifier state machine
// Idle, pressed, waiting for a second press and second press held; turns
// debounced edges and saturating elapsed timers into press events.
// ----------------------------------------------------------------------------
module bpc_fsm
  import bpc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      adv,
  input  bpc_deb_t  deb_i,
  input  bpc_cfg_t  cfg_i,
  output press_ev_t ev_o
);

  typedef enum logic [1:0] {
    ST_IDLE    = 2'd0,
    ST_PRESSED = 2'd1,
    ST_WAIT    = 2'd2,
    ST_SECOND  = 2'd3
  } state_t;

  state_t    state_r, state_nxt;
  timer_t    press_r, press_nxt;
  timer_t    rel_r, rel_nxt;
  logic      long_r, long_nxt;
  press_ev_t ev;
  logic      press_edge, rel_edge;

  assign press_edge = deb_i.chg && !deb_i.level;
  assign rel_edge   = deb_i.chg &&  deb_i.level;

  // next state and event
  always_comb begin
    state_nxt = state_r;
    press_nxt = press_r;
    rel_nxt   = rel_r;
    long_nxt  = long_r;
    ev        = EV_NONE;
    case (state_r)
      ST_IDLE: begin
        if (press_edge) begin
          press_nxt = '0;
          long_nxt  = 1'b0;
          state_nxt = ST_PRESSED;
        end
      end
      ST_PRESSED: begin
        press_nxt = sat_inc(press_r);
        if (!long_r && (CMP_W'(press_nxt) >= CMP_W'(cfg_i.long_press_ticks))) begin
          long_nxt = 1'b1;
          ev       = EV_LONG;
        end
        if (rel_edge) begin
          if (long_nxt) begin
            state_nxt = ST_IDLE;
          end else begin
            rel_nxt   = '0;
            state_nxt = ST_WAIT;
          end
        end
      end
      ST_WAIT: begin
        rel_nxt = sat_inc(rel_r);
        if (press_edge) begin
          press_nxt = '0;
          state_nxt = ST_SECOND;
        end else if (CMP_W'(rel_nxt) >= CMP_W'(cfg_i.double_window_ticks)) begin
          ev        = EV_SINGLE;
          state_nxt = ST_IDLE;
        end
      end
      ST_SECOND: begin
        press_nxt = sat_inc(press_r);
        if (rel_edge) begin
          ev        = EV_DOUBLE;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign ev_o = ev;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      press_r <= '0;
      rel_r   <= '0;
      long_r  <= 1'b0;
    end else if (adv) begin
      state_r <= state_nxt;
      press_r <= press_nxt;
      rel_r   <= rel_nxt;
      long_r  <= long_nxt;
    end
  end

  // long press only fires from the first press
  a_long_src: assert property (@(posedge clk) disable iff (!rst_n)
    adv && ev == EV_LONG |-> state_r == ST_PRESSED)
    else $error("long press outside pressed state");

  // double press only on release of the second press
  a_double_src: assert property (@(posedge clk) disable iff (!rst_n)
    adv && ev == EV_DOUBLE |-> state_r == ST_SECOND && rel_edge)
    else $error("double press without second release");

  // a long press is reported at most once per hold
  a_long_once: assert property (@(posedge clk) disable iff (!rst_n)
    adv && long_r |-> ev != EV_LONG)
    else $error("long press reported twice");

endmodule
